### rtl/core/user_string_utf16_to_utf8_core_defines.svh
// Assertion macros shared by the UTF-16 to UTF-8 checker.
// Depends on nothing; the including scope provides clk and rst.
`ifndef USER_STRING_UTF16_TO_UTF8_CORE_DEFINES_SVH
`define USER_STRING_UTF16_TO_UTF8_CORE_DEFINES_SVH

// Property checked only out of reset.
`define U16U8_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define U16U8_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/u16u8_pkg.sv
// Types and constants for the UTF-16LE to UTF-8 string decoder.
// Used by every module of the block; depends on nothing.
package u16u8_pkg;

  // Entry parser phase
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_PAYLOAD,
    PH_DROP
  } phase_t;

  // What the back end does after an optional truncation marker
  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_CP,
    ACT_MARK
  } act_t;

  // Error codes carried on done markers
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EVEN  = 2'd1;
  localparam logic [1:0] ERR_SURR  = 2'd2;
  localparam logic [1:0] ERR_TRUNC = 2'd3;

  // Length prefix marks
  localparam logic [7:0] PREFIX_TWO  = 8'h80;
  localparam logic [7:0] PREFIX_FOUR = 8'hC0;

  localparam int CP_W = 21;

  // Job queue; depth must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       entry_start;
  } in_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       byte_valid;
    logic       last_of_run;
    logic       string_done;
    logic [1:0] error_code;
  } out_t;

  // One classified input byte
  typedef struct packed {
    logic            trunc;   // close the old entry with a truncation marker first
    act_t            act;
    logic [1:0]      nlast;   // UTF-8 length of cp minus one
    logic [CP_W-1:0] cp;
    logic [1:0]      err;     // error of an ACT_MARK marker
  } job_t;

  // Queue status toward the back end
  typedef struct packed {
    logic full;
    logic valid;
  } qstat_t;

endpackage

### rtl/core/user_string_utf16_to_utf8_core.sv
// Top level of the streaming UTF-16LE to UTF-8 string decoder.
// Depends on u16u8_pkg, u16u8_front, u16u8_fifo and u16u8_back.
//
// src carries raw heap bytes (data_byte, entry_start); dst carries results
// (utf8_byte, byte_valid, last_of_run, string_done, error_code), both with
// valid/ready. One input byte makes zero to four results; the last result of
// a byte has last_of_run set.
// Path: an accepted byte's job goes into the job queue, then into the back
// end's current-job register, then its first result into the output register.
// Throughput: the front end takes one byte per cycle while the four-entry job
// queue has room; the back end emits one result per cycle while dst is not
// stalled and the queue has work, so a byte that makes several results holds
// the back end until its last result (one byte per cycle at best).
// Reset: parser goes idle, queue and output register empty; no clearing pass.
// A stall on dst holds the output register; the back end stops, the queue
// fills, and src_ready drops once the queue is full.
module user_string_utf16_to_utf8_core #(
  parameter int LENGTH_BITS = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  u16u8_pkg::in_t    src_data,
  output logic              dst_valid,
  input  logic              dst_ready,
  output u16u8_pkg::out_t   dst_data
);

  logic               push;
  logic               pop;
  u16u8_pkg::job_t    push_job;
  u16u8_pkg::job_t    head;
  u16u8_pkg::qstat_t  qstat;

  // Classify input bytes
  u16u8_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_data   (src_data),
    .queue_full (qstat.full),
    .push       (push),
    .job        (push_job)
  );

  // Decouple front and back
  u16u8_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (qstat)
  );

  // Expand jobs into results
  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .head      (head),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
  );

endmodule

### rtl/core/u16u8_fifo.sv
// Short job queue between the front and back ends of the decoder.
// Depends on u16u8_pkg.
module u16u8_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  u16u8_pkg::job_t     push_job,
  input  logic                pop,
  output u16u8_pkg::job_t     head,
  output u16u8_pkg::qstat_t   stat
);

  u16u8_pkg::job_t                    slots [u16u8_pkg::QUEUE_DEPTH];
  logic [u16u8_pkg::QPTR_W-1:0]       wr_ptr;
  logic [u16u8_pkg::QPTR_W-1:0]       rd_ptr;
  logic [u16u8_pkg::QCNT_W-1:0]       count;

  // Write a slot on push
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  assign head       = slots[rd_ptr];
  assign stat.valid = (count != '0);
  assign stat.full  = (count == u16u8_pkg::QCNT_W'(u16u8_pkg::QUEUE_DEPTH));

endmodule

### rtl/core/u16u8_front.sv
// Front end: parses the length prefix, pairs UTF-16LE bytes and surrogates,
// and classifies each input byte into a job. Depends on u16u8_pkg.
module u16u8_front #(
  parameter int LENGTH_BITS = 30
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  u16u8_pkg::in_t    src_data,
  input  logic              queue_full,
  output logic              push,
  output u16u8_pkg::job_t   job
);

  u16u8_pkg::phase_t        phase, phase_next;
  logic [1:0]               hdr_left, hdr_left_next;
  logic [LENGTH_BITS-1:0]   rem, rem_next;
  logic                     ovf, ovf_next;
  logic [7:0]               hold, hold_next;
  logic [9:0]               hsb, hsb_next;
  logic                     hp, hp_next;

  logic                     accept;
  logic [7:0]               b;
  logic [15:0]              u;
  logic                     is_hi, is_lo;
  logic [LENGTH_BITS+7:0]   hdr_wide;
  logic [LENGTH_BITS-1:0]   hd_len;
  logic                     hd_ovf;
  logic                     hd_fire;

  assign src_ready = !queue_full;
  assign accept    = src_valid && src_ready;
  assign b         = src_data.data_byte;
  assign u         = {b, hold};
  assign is_hi     = (u[15:10] == 6'b110110);
  assign is_lo     = (u[15:10] == 6'b110111);
  assign hdr_wide  = {rem, b};

  // Length as it stands once the header closes with this byte
  always_comb begin
    if (src_data.entry_start) begin
      hd_len = LENGTH_BITS'(b);
      hd_ovf = 1'b0;
    end else begin
      hd_len = hdr_wide[LENGTH_BITS-1:0];
      hd_ovf = ovf || (|hdr_wide[LENGTH_BITS+7:LENGTH_BITS]);
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= u16u8_pkg::PH_IDLE;
      hdr_left <= '0;
      rem      <= '0;
      ovf      <= 1'b0;
      hold     <= '0;
      hsb      <= '0;
      hp       <= 1'b0;
    end else begin
      phase    <= phase_next;
      hdr_left <= hdr_left_next;
      rem      <= rem_next;
      ovf      <= ovf_next;
      hold     <= hold_next;
      hsb      <= hsb_next;
      hp       <= hp_next;
    end
  end

  // Next state and job classification
  always_comb begin
    phase_next    = phase;
    hdr_left_next = hdr_left;
    rem_next      = rem;
    ovf_next      = ovf;
    hold_next     = hold;
    hsb_next      = hsb;
    hp_next       = hp;
    hd_fire       = 1'b0;
    job           = '0;
    job.act       = u16u8_pkg::ACT_NONE;

    if (accept) begin
      if (src_data.entry_start) begin
        job.trunc = (phase == u16u8_pkg::PH_HEADER) || (phase == u16u8_pkg::PH_PAYLOAD);
        hp_next   = 1'b0;
        hsb_next  = '0;
        hold_next = '0;
        ovf_next  = 1'b0;
        if ((b & u16u8_pkg::PREFIX_FOUR) == u16u8_pkg::PREFIX_FOUR) begin
          rem_next      = LENGTH_BITS'(b[5:0]);
          hdr_left_next = 2'd3;
          phase_next    = u16u8_pkg::PH_HEADER;
        end else if ((b & u16u8_pkg::PREFIX_TWO) != '0) begin
          rem_next      = LENGTH_BITS'(b[5:0]);
          hdr_left_next = 2'd1;
          phase_next    = u16u8_pkg::PH_HEADER;
        end else begin
          rem_next      = hd_len;
          hdr_left_next = 2'd0;
          hd_fire       = 1'b1;
        end
      end else begin
        unique case (phase)
          u16u8_pkg::PH_HEADER: begin
            rem_next      = hd_len;
            ovf_next      = hd_ovf;
            hdr_left_next = hdr_left - 2'd1;
            hd_fire       = (hdr_left == 2'd1);
          end
          u16u8_pkg::PH_PAYLOAD: begin
            if (rem <= LENGTH_BITS'(1)) begin
              // flag byte closes the entry
              rem_next = '0;
              job.act  = u16u8_pkg::ACT_MARK;
              if (hp) begin
                job.err    = u16u8_pkg::ERR_SURR;
                hp_next    = 1'b0;
                phase_next = u16u8_pkg::PH_DROP;
              end else begin
                job.err    = u16u8_pkg::ERR_OK;
                phase_next = u16u8_pkg::PH_IDLE;
              end
            end else if (rem[0]) begin
              hold_next = b;
              rem_next  = rem - LENGTH_BITS'(1);
            end else begin
              rem_next = rem - LENGTH_BITS'(1);
              if (hp) begin
                if (is_lo) begin
                  hp_next = 1'b0;
                  job.act = u16u8_pkg::ACT_CP;
                  job.cp  = 21'h10000 + {1'b0, hsb, u[9:0]};
                end else begin
                  job.act    = u16u8_pkg::ACT_MARK;
                  job.err    = u16u8_pkg::ERR_SURR;
                  hp_next    = 1'b0;
                  phase_next = u16u8_pkg::PH_DROP;
                end
              end else if (is_hi) begin
                hsb_next = u[9:0];
                hp_next  = 1'b1;
              end else if (is_lo) begin
                job.act    = u16u8_pkg::ACT_MARK;
                job.err    = u16u8_pkg::ERR_SURR;
                phase_next = u16u8_pkg::PH_DROP;
              end else begin
                job.act = u16u8_pkg::ACT_CP;
                job.cp  = u16u8_pkg::CP_W'(u);
              end
            end
          end
          default: ;
        endcase
      end

      // Header complete: check the length
      if (hd_fire) begin
        if (!hd_ovf && hd_len == '0) begin
          job.act    = u16u8_pkg::ACT_MARK;
          job.err    = u16u8_pkg::ERR_OK;
          phase_next = u16u8_pkg::PH_IDLE;
        end else if (!hd_len[0]) begin
          job.act    = u16u8_pkg::ACT_MARK;
          job.err    = u16u8_pkg::ERR_EVEN;
          hp_next    = 1'b0;
          phase_next = u16u8_pkg::PH_DROP;
        end else if (hd_ovf) begin
          job.act    = u16u8_pkg::ACT_MARK;
          job.err    = u16u8_pkg::ERR_TRUNC;
          hp_next    = 1'b0;
          phase_next = u16u8_pkg::PH_DROP;
        end else begin
          phase_next = u16u8_pkg::PH_PAYLOAD;
        end
      end
    end

    // UTF-8 length of the code point
    if (job.cp[20:16] != '0)     job.nlast = 2'd3;
    else if (job.cp[15:11] != '0) job.nlast = 2'd2;
    else if (job.cp[10:7] != '0)  job.nlast = 2'd1;
    else                          job.nlast = 2'd0;
  end

  assign push = accept && (job.trunc || job.act != u16u8_pkg::ACT_NONE);

endmodule

### rtl/core/u16u8_back.sv
// Back end: expands queued jobs into UTF-8 bytes and done markers in
// the output register, one per cycle unless dst stalls. Depends on u16u8_pkg.
module u16u8_back (
  input  logic                clk,
  input  logic                rst,
  input  u16u8_pkg::qstat_t   qstat,
  input  u16u8_pkg::job_t     head,
  output logic                pop,
  output logic                dst_valid,
  input  logic                dst_ready,
  output u16u8_pkg::out_t     dst_data
);

  u16u8_pkg::job_t  cur, cur_next;
  logic             cur_valid, cur_valid_next;
  logic [1:0]       idx, idx_next;
  u16u8_pkg::out_t  res;
  logic             res_end;
  logic             adv;
  logic             emit;
  logic [7:0]       cp_byte;

  assign adv  = !dst_valid || dst_ready;
  assign emit = cur_valid && adv;
  assign pop  = qstat.valid && (!cur_valid || (emit && res_end));

  // Pick the UTF-8 byte at the current position
  always_comb begin
    case ({cur.nlast, idx})
      4'b0000: cp_byte = {1'b0, cur.cp[6:0]};
      4'b0100: cp_byte = {3'b110, cur.cp[10:6]};
      4'b0101: cp_byte = {2'b10, cur.cp[5:0]};
      4'b1000: cp_byte = {4'b1110, cur.cp[15:12]};
      4'b1001: cp_byte = {2'b10, cur.cp[11:6]};
      4'b1010: cp_byte = {2'b10, cur.cp[5:0]};
      4'b1100: cp_byte = {5'b11110, cur.cp[20:18]};
      4'b1101: cp_byte = {2'b10, cur.cp[17:12]};
      4'b1110: cp_byte = {2'b10, cur.cp[11:6]};
      4'b1111: cp_byte = {2'b10, cur.cp[5:0]};
      default: cp_byte = '0;
    endcase
  end

  // Build the next result and the job's remaining work
  always_comb begin
    res      = '0;
    res_end  = 1'b0;
    cur_next = cur;
    idx_next = idx;
    if (cur.trunc) begin
      res.string_done = 1'b1;
      res.error_code  = u16u8_pkg::ERR_TRUNC;
      res_end         = (cur.act == u16u8_pkg::ACT_NONE);
      res.last_of_run = res_end;
      cur_next.trunc  = 1'b0;
    end else if (cur.act == u16u8_pkg::ACT_MARK) begin
      res.string_done = 1'b1;
      res.error_code  = cur.err;
      res.last_of_run = 1'b1;
      res_end         = 1'b1;
    end else begin
      res.utf8_byte   = cp_byte;
      res.byte_valid  = 1'b1;
      res_end         = (idx == cur.nlast);
      res.last_of_run = res_end;
      idx_next        = idx + 2'd1;
    end

    cur_valid_next = cur_valid;
    if (emit && res_end) cur_valid_next = 1'b0;
    if (pop) begin
      cur_next       = head;
      idx_next       = '0;
      cur_valid_next = 1'b1;
    end else if (!emit) begin
      cur_next = cur;
      idx_next = idx;
    end
  end

  // Hold the current job
  always_ff @(posedge clk) begin
    cur <= cur_next;
    idx <= idx_next;
    if (emit) dst_data <= res;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      dst_valid <= 1'b0;
    end else begin
      cur_valid <= cur_valid_next;
      if (adv) dst_valid <= cur_valid;
    end
  end

endmodule

### rtl/core/u16u8_checker.sv
// Port-level checks for the UTF-16 to UTF-8 decoder, bound to the top level.
// Depends on u16u8_pkg and user_string_utf16_to_utf8_core_defines.svh.
`include "user_string_utf16_to_utf8_core_defines.svh"

module u16u8_port_props (
  input logic              clk,
  input logic              rst,
  input logic              dst_valid,
  input logic              dst_ready,
  input u16u8_pkg::out_t   dst_data
);

  logic data_beat;
  logic mark_beat;
  logic data_clean;
  logic mark_form;
  logic dst_stall;

  // Classify the beat on the output channel
  assign data_beat  = dst_valid && dst_data.byte_valid;
  assign mark_beat  = dst_valid && !dst_data.byte_valid;
  assign data_clean = (dst_data.error_code == u16u8_pkg::ERR_OK) && !dst_data.string_done;
  assign mark_form  = (dst_data.utf8_byte == 8'h00) && dst_data.string_done;
  assign dst_stall  = dst_valid && !dst_ready;

  // Data beats carry no error and do not end the string
  `U16U8_CHECK(a_data_clean, data_beat |-> data_clean, "data beat with error or done")

  // Markers carry a zero byte and end the string
  `U16U8_CHECK(a_marker_form, mark_beat |-> mark_form, "malformed done marker")

  // A stalled result holds
  `U16U8_CHECK(a_dst_hold, dst_stall |=> (dst_valid && $stable(dst_data)), "result changed under stall")

  // Nothing is offered right after reset
  `U16U8_CHECK_ALWAYS(a_rst_empty, rst |=> !dst_valid, "result offered after reset")

endmodule

bind user_string_utf16_to_utf8_core u16u8_port_props u_checker (.*);
